// ----- src/hcil_pkg.sv -----
package hcil_pkg;

  localparam int REG_W     = 12;
  localparam int GAIN_W    = 16;
  localparam int INT_FRAC  = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_ADR_W = 3;
  localparam int PC_W      = 3;
  localparam int OUT_W     = ((4 * REG_W + 1 + 7) / 8) * 8;

  localparam logic [REG_W-1:0]  CENTER_RST = 12'd3077;
  localparam logic [GAIN_W-1:0] SCALE_RST  = 16'd39322;
  localparam logic [REG_W-1:0]  OFFSET_RST = 12'd0;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd1638;
  localparam logic [REG_W-1:0]  BAND_RST   = 12'd50;
  localparam logic [REG_W-1:0]  LIMIT_RST  = 12'd2300;

  typedef enum logic [CFG_ADR_W-1:0] {
    REG_CURRENT_CENTER   = 3'd0,
    REG_REFERENCE_SCALE  = 3'd1,
    REG_REFERENCE_OFFSET = 3'd2,
    REG_INTEGRAL_GAIN    = 3'd3,
    REG_BAND_LIMIT       = 3'd4,
    REG_DUTY_LIMIT       = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    HOLD_NONE = 2'd0,
    HOLD_IN   = 2'd1,
    HOLD_OUT  = 2'd2
  } hold_t;

  typedef struct packed {
    logic            accept;
    logic            ld_cur;
    logic            mul_ref;
    logic            ld_ref;
    logic            ld_err;
    logic            mul_err;
    logic            ld_int;
    logic            emit;
    hold_t           hold;
    logic            jump;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic ready;
    logic ld_cur;
    logic mul_ref;
    logic ld_ref;
    logic ld_err;
    logic mul_err;
    logic ld_int;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic [REG_W-1:0]  center;
    logic [GAIN_W-1:0] scale;
    logic [REG_W-1:0]  offset;
    logic [GAIN_W-1:0] gain;
    logic [REG_W-1:0]  band;
    logic [REG_W-1:0]  limit;
  } cfg_t;

  typedef struct packed {
    logic             in_band;
    logic [REG_W-1:0] reverse_duty_high;
    logic [REG_W-1:0] reverse_duty_low;
    logic [REG_W-1:0] forward_duty_high;
    logic [REG_W-1:0] forward_duty_low;
  } result_t;

endpackage

// ----- src/hcil_seq.sv -----
module hcil_seq
  import hcil_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic out_busy,
  output ctl_t ctl
);

  // accept/cur/mref/ref/err/merr/int/emit, hold, jump, target
  localparam ucode_t ROM [0:7] = '{
    '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, HOLD_IN,   1'b0, 3'd0},
    '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, HOLD_NONE, 1'b0, 3'd0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, HOLD_NONE, 1'b0, 3'd0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, HOLD_NONE, 1'b0, 3'd0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, HOLD_OUT,  1'b1, 3'd0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, HOLD_NONE, 1'b1, 3'd0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, HOLD_NONE, 1'b1, 3'd0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, HOLD_NONE, 1'b1, 3'd0}
  };

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          word;
  logic            hold;

  assign word = ROM[pc];

  always_comb begin
    case (word.hold)
      HOLD_NONE: hold = 1'b0;
      HOLD_IN:   hold = !in_valid;
      HOLD_OUT:  hold = out_busy;
      default:   hold = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (word.jump) begin
      pc_next = word.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctl.ready   = word.accept;
  assign ctl.ld_cur  = word.ld_cur  && !hold;
  assign ctl.mul_ref = word.mul_ref && !hold;
  assign ctl.ld_ref  = word.ld_ref  && !hold;
  assign ctl.ld_err  = word.ld_err  && !hold;
  assign ctl.mul_err = word.mul_err && !hold;
  assign ctl.ld_int  = word.ld_int  && !hold;
  assign ctl.emit    = word.emit    && !hold;

endmodule

// ----- src/hcil_datapath.sv -----
module hcil_datapath
  import hcil_pkg::*;
#(
  parameter int SAMPLE_BITS   = 12,
  parameter int FRACTION_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctl_t                   ctl,
  input  cfg_t                   cfg,
  input  logic [SAMPLE_BITS-1:0] current_sample_a,
  input  logic [SAMPLE_BITS-1:0] reference_sample_a,
  input  logic [SAMPLE_BITS-1:0] current_sample_b,
  input  logic [SAMPLE_BITS-1:0] reference_sample_b,
  input  logic                   drive_enable,
  input  logic                   direction_forward,
  output result_t                result
);

  localparam int S      = SAMPLE_BITS;
  localparam int F      = FRACTION_BITS;
  localparam int W_IN   = (S > REG_W) ? S : REG_W;
  localparam int CUR_W  = W_IN + F + 2;
  localparam int FC_W   = REG_W + F;
  localparam int REF_W  = W_IN + F + 2;
  localparam int ERR_W  = REF_W + 1;
  localparam int MA_W   = ERR_W;
  localparam int MB_W   = GAIN_W + 1;
  localparam int P_W    = MA_W + MB_W;
  localparam int SH_REF = GAIN_W + 1 - F;
  localparam int INT_W  = REG_W + INT_FRAC;

  logic [FC_W-1:0]         filtered_current;
  logic signed [REF_W-1:0] filtered_reference;
  logic [INT_W-1:0]        duty_integrator;
  logic signed [ERR_W-1:0] err;
  logic                    in_band_q;
  logic signed [P_W-1:0]   prod;
  logic                    enable_q;
  logic                    forward_q;

  logic [S:0]              sum_c;
  logic [S:0]              sum_r;
  logic signed [CUR_W-1:0] cur_new;
  logic signed [CUR_W:0]   cur_sum;
  logic signed [CUR_W:0]   cur_avg;
  logic [FC_W-1:0]         filtered_current_next;
  logic signed [P_W-1:0]   prod_sh;
  logic signed [REF_W-1:0] ref_new;
  logic signed [REF_W:0]   ref_sum;
  logic signed [REF_W:0]   ref_avg;
  logic signed [ERR_W-1:0] err_next;
  logic [ERR_W-1:0]        mag;
  logic [ERR_W-1:0]        band_q;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [P_W-1:0]   inc;
  logic signed [P_W:0]     int_sum;
  logic [INT_W-1:0]        limit_q;
  logic [INT_W-1:0]        duty_integrator_next;
  logic [REG_W-1:0]        duty;

  assign sum_c = {1'b0, current_sample_a} + {1'b0, current_sample_b};
  assign sum_r = {1'b0, reference_sample_a} + {1'b0, reference_sample_b};

  // center - mean(ca, cb), in counts with F fraction bits
  assign cur_new = $signed({{(CUR_W-REG_W-F){1'b0}}, cfg.center, {F{1'b0}}})
                 - $signed({{(CUR_W-S-F){1'b0}}, sum_c, {(F-1){1'b0}}});
  assign cur_sum = $signed({{(CUR_W+1-FC_W){1'b0}}, filtered_current})
                 + $signed({cur_new[CUR_W-1], cur_new});
  assign cur_avg = cur_sum >>> 1;
  assign filtered_current_next = cur_avg[CUR_W] ? '0 : cur_avg[FC_W-1:0];

  assign prod_sh = prod >>> SH_REF;
  assign ref_new = $signed(prod_sh[REF_W-1:0])
                 - $signed({{(REF_W-REG_W-F){1'b0}}, cfg.offset, {F{1'b0}}});
  assign ref_sum = $signed({filtered_reference[REF_W-1], filtered_reference})
                 + $signed({ref_new[REF_W-1], ref_new});
  assign ref_avg = ref_sum >>> 1;

  assign err_next = $signed({filtered_reference[REF_W-1], filtered_reference})
                  - $signed({{(ERR_W-FC_W){1'b0}}, filtered_current});
  assign mag      = err_next[ERR_W-1] ? ERR_W'(-err_next) : ERR_W'(err_next);
  assign band_q   = {{(ERR_W-REG_W-F){1'b0}}, cfg.band, {F{1'b0}}};

  // shared multiplier: reference gain or integral gain
  assign mul_a = ctl.mul_ref ? $signed({{(MA_W-S-1){1'b0}}, sum_r}) : err;
  assign mul_b = ctl.mul_ref ? $signed({1'b0, cfg.scale}) : $signed({1'b0, cfg.gain});

  assign inc     = prod >>> F;
  assign int_sum = $signed({inc[P_W-1], inc})
                 + $signed({{(P_W+1-INT_W){1'b0}}, duty_integrator});
  assign limit_q = {cfg.limit, {INT_FRAC{1'b0}}};

  always_comb begin
    if (int_sum[P_W]) begin
      duty_integrator_next = '0;
    end else if (int_sum > $signed({{(P_W+1-INT_W){1'b0}}, limit_q})) begin
      duty_integrator_next = limit_q;
    end else begin
      duty_integrator_next = int_sum[INT_W-1:0];
    end
  end

  assign duty = duty_integrator_next[INT_W-1 -: REG_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_current   <= '0;
      filtered_reference <= '0;
      duty_integrator    <= '0;
    end else begin
      if (ctl.ld_cur) begin
        filtered_current <= filtered_current_next;
      end
      if (ctl.ld_ref) begin
        filtered_reference <= ref_avg[REF_W-1:0];
      end
      if (ctl.ld_int) begin
        duty_integrator <= duty_integrator_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_cur) begin
      enable_q  <= drive_enable;
      forward_q <= direction_forward;
    end
    if (ctl.mul_ref || ctl.mul_err) begin
      prod <= mul_a * mul_b;
    end
    if (ctl.ld_err) begin
      err       <= err_next;
      in_band_q <= (mag < band_q);
    end
  end

  always_comb begin
    result                   = '0;
    result.in_band           = in_band_q;
    if (enable_q && forward_q) begin
      result.forward_duty_low  = duty;
      result.forward_duty_high = duty;
    end
    if (enable_q && !forward_q) begin
      result.reverse_duty_low  = duty;
      result.reverse_duty_high = duty;
    end
  end

endmodule

// ----- src/hbridge_current_integral_loop_core.sv -----
// channel     dir  handshake                      payload
// s_axis      in   s_axis_tvalid / s_axis_tready  s_axis_tdata: samples, enable, direction
// m_axis      out  m_axis_tvalid / m_axis_tready  m_axis_tdata: four compares, in_band
// cfg         in   cfg_wr_en                      cfg_addr, cfg_wdata
//
// Each item runs through the control program, whose steps share a single
// multiplier and the filter/integrator adders.
// s_axis_tready is high only at program step 0; a result held by m_axis_tready
// low stalls the program at its last step. Synchronous reset clears the
// filters, the integrator, the step counter and the output valid.
module hbridge_current_integral_loop_core
  import hcil_pkg::*;
#(
  parameter int SAMPLE_BITS   = 12,
  parameter int FRACTION_BITS = 8,
  localparam int IN_W = ((4 * SAMPLE_BITS + 2 + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // current_sample_a, reference_sample_a, current_sample_b, reference_sample_b,
  // drive_enable, direction_forward, zero pad
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // forward_duty_low, forward_duty_high, reverse_duty_low, reverse_duty_high,
  // in_band, zero pad
  output logic [OUT_W-1:0]     m_axis_tdata,
  input  logic                 cfg_wr_en,
  input  logic [CFG_ADR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int S = SAMPLE_BITS;

  cfg_t    cfg;
  ctl_t    ctl;
  result_t result;
  logic    out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center <= CENTER_RST;
      cfg.scale  <= SCALE_RST;
      cfg.offset <= OFFSET_RST;
      cfg.gain   <= GAIN_RST;
      cfg.band   <= BAND_RST;
      cfg.limit  <= LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_CURRENT_CENTER:   cfg.center <= cfg_wdata[REG_W-1:0];
        REG_REFERENCE_SCALE:  cfg.scale  <= cfg_wdata[GAIN_W-1:0];
        REG_REFERENCE_OFFSET: cfg.offset <= cfg_wdata[REG_W-1:0];
        REG_INTEGRAL_GAIN:    cfg.gain   <= cfg_wdata[GAIN_W-1:0];
        REG_BAND_LIMIT:       cfg.band   <= cfg_wdata[REG_W-1:0];
        REG_DUTY_LIMIT:       cfg.limit  <= cfg_wdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_busy      = m_axis_tvalid && !m_axis_tready;
  assign s_axis_tready = ctl.ready;

  hcil_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .out_busy (out_busy),
    .ctl      (ctl)
  );

  hcil_datapath #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .ctl                (ctl),
    .cfg                (cfg),
    .current_sample_a   (s_axis_tdata[S-1:0]),
    .reference_sample_a (s_axis_tdata[2*S-1:S]),
    .current_sample_b   (s_axis_tdata[3*S-1:2*S]),
    .reference_sample_b (s_axis_tdata[4*S-1:3*S]),
    .drive_enable       (s_axis_tdata[4*S]),
    .direction_forward  (s_axis_tdata[4*S+1]),
    .result             (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      m_axis_tdata <= {{(OUT_W-$bits(result_t)){1'b0}}, result};
    end
  end

endmodule

// ----- tb/hbridge_current_integral_loop_core_tb.sv -----
`timescale 1ns / 1ps

module hbridge_current_integral_loop_core_tb
  import hcil_pkg::*;
();

  localparam int SAMPLE_W       = 12;
  localparam int FRAC           = 8;
  localparam int IN_W           = ((4 * SAMPLE_W + 2 + 7) / 8) * 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_WAIT       = 17;

  // indexes outside the register map
  localparam logic [CFG_ADR_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_ADR_W-1:0] REG_SPARE_7 = 3'd7;

  // lowest bit up: current_sample_a, reference_sample_a, current_sample_b,
  // reference_sample_b, drive_enable, direction_forward
  typedef struct packed {
    logic                direction_forward;
    logic                drive_enable;
    logic [SAMPLE_W-1:0] reference_sample_b;
    logic [SAMPLE_W-1:0] current_sample_b;
    logic [SAMPLE_W-1:0] reference_sample_a;
    logic [SAMPLE_W-1:0] current_sample_a;
  } sample_set_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_ADR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  hbridge_current_integral_loop_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  // predictor copy of the registers and loop state
  logic [REG_W-1:0]  cfg_center = CENTER_RST;
  logic [GAIN_W-1:0] cfg_scale  = SCALE_RST;
  logic [REG_W-1:0]  cfg_offset = OFFSET_RST;
  logic [GAIN_W-1:0] cfg_gain   = GAIN_RST;
  logic [REG_W-1:0]  cfg_band   = BAND_RST;
  logic [REG_W-1:0]  cfg_limit  = LIMIT_RST;
  longint            filt_current   = 0;
  longint            filt_reference = 0;
  longint            duty_acc       = 0;

  result_t expected_results[$];
  int      gap_max = MAX_WAIT;
  int      stall_max = MAX_WAIT;
  bit      hold_request = 1'b0;
  int      mismatches = 0;
  int      items_sent = 0;
  int      results_checked = 0;
  int      cfg_writes = 0;
  int      phases = 0;
  int      idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    return SAMPLE_W'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom);
  endfunction

  function automatic result_t predict_step(input sample_set_t s);
    longint  cur_new;
    longint  ref_new;
    longint  err;
    longint  mag;
    longint  lim_q;
    longint  duty;
    result_t r;
    cur_new = (longint'(cfg_center) <<< FRAC)
            - ((longint'(s.current_sample_a) + longint'(s.current_sample_b)) <<< (FRAC - 1));
    filt_current = (filt_current + cur_new) >>> 1;
    if (filt_current < 0) filt_current = 0;
    ref_new = (((longint'(s.reference_sample_a) + longint'(s.reference_sample_b))
              * longint'(cfg_scale)) >>> (1 + INT_FRAC - FRAC))
            - (longint'(cfg_offset) <<< FRAC);
    filt_reference = (filt_reference + ref_new) >>> 1;
    err = filt_reference - filt_current;
    mag = (err < 0) ? -err : err;
    duty_acc = duty_acc + ((err * longint'(cfg_gain)) >>> FRAC);
    lim_q = longint'(cfg_limit) <<< INT_FRAC;
    if (duty_acc > lim_q) duty_acc = lim_q;
    if (duty_acc < 0) duty_acc = 0;
    duty = duty_acc >>> INT_FRAC;
    r = '0;
    if (s.drive_enable) begin
      if (s.direction_forward) begin
        r.forward_duty_low  = duty[REG_W-1:0];
        r.forward_duty_high = duty[REG_W-1:0];
      end else begin
        r.reverse_duty_low  = duty[REG_W-1:0];
        r.reverse_duty_high = duty[REG_W-1:0];
      end
    end
    r.in_band = (mag < (longint'(cfg_band) <<< FRAC));
    return r;
  endfunction

  // leaves tvalid high so a zero gap gives back-to-back transfers
  task automatic send_item(input sample_set_t item);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(item);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_results.push_back(predict_step(item));
    items_sent++;
  endtask

  task automatic drive_samples(input logic [SAMPLE_W-1:0] ca, input logic [SAMPLE_W-1:0] ra,
                               input logic [SAMPLE_W-1:0] cb, input logic [SAMPLE_W-1:0] rb,
                               input logic en, input logic fwd);
    send_item(sample_set_t'({fwd, en, rb, cb, ra, ca}));
  endtask

  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    phases++;
  endtask

  task automatic cfg_write(input logic [CFG_ADR_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_CURRENT_CENTER:   cfg_center = data[REG_W-1:0];
      REG_REFERENCE_SCALE:  cfg_scale  = data;
      REG_REFERENCE_OFFSET: cfg_offset = data[REG_W-1:0];
      REG_INTEGRAL_GAIN:    cfg_gain   = data;
      REG_BAND_LIMIT:       cfg_band   = data[REG_W-1:0];
      REG_DUTY_LIMIT:       cfg_limit  = data[REG_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic program_all(input logic [CFG_W-1:0] center, input logic [CFG_W-1:0] scale,
                             input logic [CFG_W-1:0] offset, input logic [CFG_W-1:0] gain,
                             input logic [CFG_W-1:0] band, input logic [CFG_W-1:0] limit);
    cfg_write(REG_CURRENT_CENTER, center);
    cfg_write(REG_REFERENCE_SCALE, scale);
    cfg_write(REG_REFERENCE_OFFSET, offset);
    cfg_write(REG_INTEGRAL_GAIN, gain);
    cfg_write(REG_BAND_LIMIT, band);
    cfg_write(REG_DUTY_LIMIT, limit);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    drive_samples(12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0);
    drive_samples(12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b1);
    // current above center: filter clamps at zero
    drive_samples(12'd4095, 12'd0, 12'd4095, 12'd0, 1'b1, 1'b0);
    drive_samples(12'd0, 12'd4095, 12'd0, 12'd4095, 1'b1, 1'b1);
    drive_samples(12'd0, 12'd4095, 12'd0, 12'd4095, 1'b1, 1'b0);
    // disabled: integrator still runs, direction ignored
    drive_samples(12'd0, 12'd4095, 12'd0, 12'd4095, 1'b0, 1'b1);
    drive_samples(12'd3077, 12'd2048, 12'd3077, 12'd2047, 1'b1, 1'b1);
    drive_samples(12'd2730, 12'd1365, 12'd1365, 12'd2730, 1'b1, 1'b0);
    finish_phase();
  endtask

  task automatic test_register_extremes();
    cfg_write(REG_SPARE_6, 16'hFFFF);
    cfg_write(REG_SPARE_7, 16'hA5A5);
    program_all(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    drive_samples(12'd0, 12'd4095, 12'd0, 12'd4095, 1'b1, 1'b1);
    drive_samples(12'd0, 12'd4095, 12'd0, 12'd4095, 1'b1, 1'b0);
    drive_samples(12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0, 1'b1);
    finish_phase();
    // offset above scaled mean: negative reference drives integrator to zero
    program_all(16'h0000, 16'h0000, 16'h0FFF, 16'hFFFF, 16'h0FFF, 16'h0FFF);
    drive_samples(12'd0, 12'd100, 12'd0, 12'd200, 1'b1, 1'b1);
    drive_samples(12'd0, 12'd4095, 12'd0, 12'd4095, 1'b1, 1'b0);
    drive_samples(12'd0, 12'd0, 12'd0, 12'd0, 1'b1, 1'b1);
    finish_phase();
    // zero duty limit
    program_all(16'd2048, 16'd32768, 16'd100, 16'd1000, 16'd50, 16'd0);
    drive_samples(12'd0, 12'd4095, 12'd0, 12'd4095, 1'b1, 1'b1);
    drive_samples(12'd100, 12'd3000, 12'd50, 12'd3500, 1'b1, 1'b0);
    drive_samples(12'd2048, 12'd2048, 12'd2048, 12'd2048, 1'b1, 1'b1);
    finish_phase();
  endtask

  task automatic test_backpressure();
    int n;
    program_all(CFG_W'(CENTER_RST), SCALE_RST, CFG_W'(OFFSET_RST), GAIN_RST,
                CFG_W'(BAND_RST), CFG_W'(LIMIT_RST));
    gap_max = 0;
    hold_request = 1'b1;
    for (n = 0; n < 40; n++) begin
      drive_samples(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                    rand_bit(), rand_bit());
    end
    finish_phase();
  endtask

  task automatic test_random_traffic();
    int p;
    int n;
    int lo;
    bit tracking;
    logic [SAMPLE_W-1:0] ca;
    logic [SAMPLE_W-1:0] cb;
    for (p = 0; p < 14; p++) begin
      gap_max   = (p % 4 == 1 || p % 4 == 3) ? MAX_WAIT : 0;
      stall_max = (p % 4 >= 2) ? MAX_WAIT : 0;
      if (p % 3 == 2) gap_max = MAX_WAIT;
      if (p > 0) begin
        program_all(CFG_W'($urandom),
                    CFG_W'($urandom),
                    CFG_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 300)),
                    CFG_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4000)),
                    CFG_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 600)),
                    ($urandom_range(0, 5) == 0) ? 16'(0) :
                    (($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom)));
      end
      tracking = (p % 2 == 0);
      for (n = 0; n < 100; n++) begin
        if (tracking && $urandom_range(0, 3) != 0) begin
          lo = (cfg_center > 700) ? int'(cfg_center) - 700 : 0;
          ca = SAMPLE_W'($urandom_range(lo, cfg_center));
          cb = SAMPLE_W'($urandom_range(lo, cfg_center));
          drive_samples(ca, rand_sample(), cb, rand_sample(), $urandom_range(0, 3) != 0,
                        rand_bit());
        end else begin
          drive_samples(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                        rand_bit(), rand_bit());
        end
      end
      finish_phase();
    end
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int stall;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = $urandom_range(0, stall_max);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected transfer: tdata=%h", $realtime, m_axis_tdata);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.forward_duty_low  !== want.forward_duty_low  ||
            got.forward_duty_high !== want.forward_duty_high ||
            got.reverse_duty_low  !== want.reverse_duty_low  ||
            got.reverse_duty_high !== want.reverse_duty_high ||
            got.in_band           !== want.in_band) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] #%0d exp f=%0d/%0d r=%0d/%0d b=%0b got f=%0d/%0d r=%0d/%0d b=%0b",
                     $realtime, results_checked,
                     want.forward_duty_low, want.forward_duty_high,
                     want.reverse_duty_low, want.reverse_duty_high, want.in_band,
                     got.forward_duty_low, got.forward_duty_high,
                     got.reverse_duty_low, got.reverse_duty_high, got.in_band);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_results.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    finish_phase();
    $display("Run covered %0d input transfers and %0d checked results over %0d phases,",
             items_sent, results_checked, phases);
    $display("with %0d register writes, output hold-off and random idling on both sides.",
             cfg_writes);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
